[hdl/sha_pkg.sv]
// SHA-256 shared constants and round functions.
`timescale 1ns / 1ps
package sha_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned RoundCount = 64;
	localparam int unsigned QueueDepth = 2;
	localparam logic [7:0]  PadByte    = 8'h80;
	localparam logic [5:0]  LenStart   = 6'd56;

	typedef enum logic [1:0] {
		CmdNone  = 2'd0,
		CmdBlock = 2'd1,
		CmdFinal = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [511:0] block;
		logic         last;
	} blk_req_t;

	typedef enum logic [1:0] {
		BkIdle  = 2'd0,
		BkRound = 2'd1,
		BkAdd   = 2'd2,
		BkOut   = 2'd3
	} bk_state_t;

	typedef enum logic [2:0] {
		FrGather = 3'd0,
		FrPadA   = 3'd1,
		FrPadB   = 3'd2,
		FrPush2  = 3'd3
	} fr_state_t;

	function automatic logic [255:0] init_hash();
		return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[i];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

[hdl/sha256_byte_stream_hasher_unit.sv]
// Top level of the SHA-256 byte-stream hasher.
`timescale 1ns / 1ps
// SHA-256 over a byte stream. One request carries at most one byte plus an
// end-of-message flag. A request is taken while the front is gathering (not
// padding) and the queue has room. Each full 64-byte block goes through a
// two-entry queue to the compression engine, which runs one round per cycle;
// each block takes a load, 64 rounds and a chain add. Filling the next block
// overlaps compression, so the sustained rate is set by the round loop. On
// end of message the front adds one or two padding blocks (two when more
// than 55 bytes sit in the last block). The digest is written into an output
// register in the chain-add step of the last padding block, later when
// earlier blocks are still queued or compressing. The digest is held until
// taken, and the engine accepts no new block while it waits. The chain value
// returns to the initial words after each digest.
module sha256_byte_stream_hasher_unit #(
	parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word0,
	output logic [63:0] digest_word1,
	output logic [63:0] digest_word2,
	output logic [63:0] digest_word3
);
	logic              push, room, pop, avail;
	sha_pkg::blk_req_t push_req, head;

	sha_front u_front (
		.clk, .arst_n, .data_byte, .byte_present, .end_of_message,
		.valid(in_valid), .ready(in_ready),
		.push, .push_req, .push_room(room)
	);

	sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .push, .push_req, .room, .pop, .avail, .head
	);

	sha_back u_back (
		.clk, .arst_n, .avail, .head, .pop,
		.digest_word0, .digest_word1, .digest_word2, .digest_word3,
		.out_valid, .out_ready
	);
endmodule

[hdl/sha_front.sv]
// Byte gatherer and padder: builds 64-byte blocks and pushes them to the queue.
`timescale 1ns / 1ps
module sha_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           data_byte,
	input  logic                 byte_present,
	input  logic                 end_of_message,
	input  logic                 valid,
	output logic                 ready,
	output logic                 push,
	output sha_pkg::blk_req_t    push_req,
	input  logic                 push_room
);
	sha_pkg::fr_state_t state_q, state_d;
	logic [511:0] buf_q, buf_d;
	logic [5:0]   fill_q, fill_d;
	logic [63:0]  bits_q, bits_d;
	logic [511:0] pad_blk;
	logic [63:0]  len_q;
	logic [63:0]  len_d;

	// byte i sits at bits [511-8i -: 8]
	always_comb begin
		pad_blk = buf_q;
		for (int i = 0; i < 64; i++) begin
			if (6'(i) > fill_q) pad_blk[511 - 8*i -: 8] = 8'h00;
		end
		pad_blk[511 - 8*fill_q -: 8] = sha_pkg::PadByte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::FrGather;
			fill_q  <= '0;
			bits_q  <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			bits_q  <= bits_d;
		end
	end

	always_ff @(posedge clk) begin
		buf_q <= buf_d;
		len_q <= len_d;
	end

	always_comb begin
		state_d  = state_q;
		buf_d    = buf_q;
		fill_d   = fill_q;
		bits_d   = bits_q;
		len_d    = len_q;
		push     = 1'b0;
		push_req = '0;
		ready    = 1'b0;
		case (state_q)
			sha_pkg::FrGather: begin
				ready = push_room;
				if (valid && push_room) begin
					if (byte_present) begin
						buf_d[511 - 8*fill_q -: 8] = data_byte;
						bits_d = bits_q + 64'd8;
						fill_d = fill_q + 6'd1;
						if (fill_q == 6'd63) begin
							push          = 1'b1;
							push_req.block = buf_d;
							push_req.last  = 1'b0;
						end
					end
					if (end_of_message) begin
						len_d   = bits_d;
						state_d = sha_pkg::FrPadA;
					end
				end
			end
			sha_pkg::FrPadA: begin
				if (push_room) begin
					push_req.block = pad_blk;
					if (fill_q < sha_pkg::LenStart) begin
						push_req.block[63:0] = len_q;
						push_req.last        = 1'b1;
						state_d              = sha_pkg::FrGather;
						fill_d               = '0;
						bits_d               = '0;
					end else begin
						push_req.last = 1'b0;
						state_d       = sha_pkg::FrPadB;
					end
					push = 1'b1;
				end
			end
			sha_pkg::FrPadB: begin
				if (push_room) begin
					push                 = 1'b1;
					push_req.block       = '0;
					push_req.block[63:0] = len_q;
					push_req.last        = 1'b1;
					state_d              = sha_pkg::FrGather;
					fill_d               = '0;
					bits_d               = '0;
				end
			end
			default: state_d = sha_pkg::FrGather;
		endcase
	end
endmodule

[hdl/sha_queue.sv]
// Small block-request FIFO between gatherer and compression engine.
`timescale 1ns / 1ps
module sha_queue #(
	parameter int unsigned DEPTH = sha_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sha_pkg::blk_req_t push_req,
	output logic              room,
	input  logic              pop,
	output logic              avail,
	output sha_pkg::blk_req_t head
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	sha_pkg::blk_req_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign room  = cnt_q != (AW+1)'(DEPTH);
	assign avail = cnt_q != '0;
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
			if (pop)  rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_req;
	end
endmodule

[hdl/sha_back.sv]
// SHA-256 compression engine, one round per cycle, with digest output register.
`timescale 1ns / 1ps
module sha_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              avail,
	input  sha_pkg::blk_req_t head,
	output logic              pop,
	output logic [63:0]       digest_word0,
	output logic [63:0]       digest_word1,
	output logic [63:0]       digest_word2,
	output logic [63:0]       digest_word3,
	output logic              out_valid,
	input  logic              out_ready
);
	sha_pkg::bk_state_t state_q, state_d;
	logic [255:0] h_q;
	logic [31:0]  v_q [8];
	logic [31:0]  w_q [16];
	logic [5:0]   rnd_q;
	logic         last_q;
	logic [255:0] dig_q;
	logic         ov_q;
	logic [31:0]  t1, t2, wn, s0, s1, ch, mj, b0, b1;
	logic [255:0] sum;

	always_comb begin
		b1 = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11) ^ sha_pkg::rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + b1 + ch + sha_pkg::round_k(rnd_q) + w_q[0];
		b0 = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13) ^ sha_pkg::rotr(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = b0 + mj;
		s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = s1 + w_q[9] + s0 + w_q[0];
		for (int i = 0; i < 8; i++)
			sum[255 - 32*i -: 32] = h_q[255 - 32*i -: 32] + v_q[i];
	end

	assign pop          = (state_q == sha_pkg::BkIdle) && avail && !ov_q;
	assign out_valid    = ov_q;
	assign digest_word0 = dig_q[255:192];
	assign digest_word1 = dig_q[191:128];
	assign digest_word2 = dig_q[127:64];
	assign digest_word3 = dig_q[63:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			sha_pkg::BkIdle:  if (pop) state_d = sha_pkg::BkRound;
			sha_pkg::BkRound: if (rnd_q == 6'd63) state_d = sha_pkg::BkAdd;
			sha_pkg::BkAdd:   state_d = sha_pkg::BkIdle;
			default:          state_d = sha_pkg::BkIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::BkIdle;
			h_q     <= sha_pkg::init_hash();
			ov_q    <= 1'b0;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ov_q && out_ready) ov_q <= 1'b0;
			if (pop) rnd_q <= '0;
			else if (state_q == sha_pkg::BkRound) rnd_q <= rnd_q + 6'd1;
			if (state_q == sha_pkg::BkAdd) begin
				if (last_q) begin
					h_q  <= sha_pkg::init_hash();
					ov_q <= 1'b1;
				end else begin
					h_q <= sum;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			last_q <= head.last;
			for (int i = 0; i < 16; i++) w_q[i] <= head.block[511 - 32*i -: 32];
			for (int i = 0; i < 8; i++)  v_q[i] <= h_q[255 - 32*i -: 32];
		end else if (state_q == sha_pkg::BkRound) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (state_q == sha_pkg::BkAdd && last_q) dig_q <= sum;
	end
endmodule

[bench/sha256_digest_checker.sv]
// Watches the request and digest channels, predicts SHA-256 digests, compares them.
`timescale 1ns / 1ps
module sha256_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] digest_word0,
	input  logic [63:0] digest_word1,
	input  logic [63:0] digest_word2,
	input  logic [63:0] digest_word3,
	output int          fail_count,
	output int          digest_count,
	output int          pending_digests
);

	localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	localparam logic [31:0] KTAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	logic [31:0]  hash_state [8];
	logic [7:0]   blk [64];
	int unsigned  fill;
	logic [63:0]  bit_len;
	logic [255:0] digest_q [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		v = hash_state;
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += v[i];
	endtask

	task automatic absorb(input logic [7:0] b, input logic has_byte, input logic last);
		logic [255:0] d;
		if (has_byte) begin
			blk[fill] = b;
			fill++;
			bit_len += 64'd8;
			if (fill == 64) begin
				compress();
				fill = 0;
			end
		end
		if (last) begin
			blk[fill] = 8'h80;
			fill++;
			if (fill > 56) begin
				for (int i = fill; i < 64; i++) blk[i] = 8'h00;
				compress();
				fill = 0;
			end
			for (int i = fill; i < 56; i++) blk[i] = 8'h00;
			for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
			compress();
			for (int i = 0; i < 8; i++) d[255-32*i -: 32] = hash_state[i];
			digest_q.push_back(d);
			hash_state = IV;
			fill = 0;
			bit_len = '0;
		end
	endtask

	initial begin
		hash_state = IV;
		fill = 0;
		bit_len = '0;
		fail_count = 0;
		digest_count = 0;
	end

	assign pending_digests = digest_q.size();

	always @(posedge clk) begin
		logic [255:0] want, got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {digest_word0, digest_word1, digest_word2, digest_word3};
				digest_count++;
				if (digest_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected digest %h", $time, got);
				end else begin
					want = digest_q.pop_front();
					for (int k = 0; k < 4; k++)
						if (want[255-64*k -: 64] !== got[255-64*k -: 64]) begin
							fail_count++;
							$display("%0t: digest_word%0d expected %h actual %h", $time, k,
								want[255-64*k -: 64], got[255-64*k -: 64]);
						end
				end
			end
			if (in_valid && in_ready)
				absorb(data_byte, byte_present, end_of_message);
		end
	end

endmodule

[bench/tb_top.sv]
// Stimulus and verdict for the SHA-256 byte-stream hasher.
`timescale 1ns / 1ps
module tb_top;

	localparam int IDLE_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        byte_present = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] digest_word0, digest_word1, digest_word2, digest_word3;
	int          fail_count, digest_count, pending_digests;
	int          request_count = 0;
	int          quiet_cycles = 0;

	always #10 clk = ~clk;

	sha256_byte_stream_hasher_unit u_top (.*);

	sha256_digest_checker u_chk (.*);

	// Watchdog: counts cycles without any accepted request or digest.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("sha256_byte_stream_hasher_unit verification failed");
			$finish;
		end
	end

	// Digest side: random stalls with stretches of always-ready.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			repeat (gap) @(posedge clk);
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			out_ready <= 1'b0;
		end
	end

	// One request; waits a random gap first unless burst, holds valid until accepted.
	task automatic send(input logic [7:0] b, input logic has_byte, input logic last,
		input bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		byte_present <= has_byte;
		end_of_message <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		request_count++;
	endtask

	// Message of n random bytes; end flag rides on the last byte or on an empty request.
	task automatic send_message(input int n, input bit burst);
		bit sep_end;
		sep_end = (n == 0) || ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++) begin
			send(8'($urandom_range(0, 255)), 1'b1, !sep_end && (i == n - 1), burst);
			if ($urandom_range(0, 9) == 0)
				send(8'($urandom_range(0, 255)), 1'b0, 1'b0, burst);
		end
		if (sep_end) send(8'($urandom_range(0, 255)), 1'b0, 1'b1, burst);
	endtask

	initial begin
		int n;
		bit burst;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, "abc", padding boundaries, extreme bytes.
		send(8'h00, 1'b0, 1'b1, 1'b0);
		send(8'h61, 1'b1, 1'b0, 1'b0);
		send(8'h62, 1'b1, 1'b0, 1'b0);
		send(8'h63, 1'b1, 1'b1, 1'b0);
		send(8'hff, 1'b0, 1'b0, 1'b0);
		send(8'hff, 1'b1, 1'b1, 1'b0);
		send(8'h00, 1'b1, 1'b0, 1'b0);
		send(8'h00, 1'b0, 1'b1, 1'b0);
		// One-block, two-block, and full-block padding layouts.
		send_message(55, 1'b1);
		send_message(56, 1'b1);
		send_message(64, 1'b1);

		// Random messages, mostly short, with long bursts and idle noise.
		while (request_count < 1250) begin
			burst = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0:       n = 0;
				1:       n = $urandom_range(50, 130);
				default: n = $urandom_range(1, 20);
			endcase
			send_message(n, burst);
		end
		in_valid <= 1'b0;

		while (pending_digests != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d requests; %0d digests checked, %0d mismatches.",
			request_count, digest_count, fail_count);
		if (fail_count == 0)
			$display("sha256_byte_stream_hasher_unit verification clean");
		else
			$display("sha256_byte_stream_hasher_unit verification failed");
		$finish;
	end

endmodule
